FILE: rtl/core/asym_4bit_dequant_dot_product_assert.svh
// Assertion helpers shared by the core modules.
// Every check is clocked on i_clk and is switched off while reset is held.
`ifndef ASYM_4BIT_DEQUANT_DOT_PRODUCT_ASSERT_SVH
`define ASYM_4BIT_DEQUANT_DOT_PRODUCT_ASSERT_SVH

// A property that must hold at every clock edge.
`define AQDOT_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define AQDOT_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/aqdot_pkg.sv
`default_nettype none

package aqdot_pkg;

    // Field widths of the incoming word.
    localparam int ACT_BITS    = 16;
    localparam int COEF_BITS   = 16;
    localparam int CODE_BITS   = 4;
    localparam logic [CODE_BITS-1:0] CODE_MASK = 4'hF;

    // The dequantised weight is exact in Q.12 and needs 20 bits.
    localparam int WEIGHT_BITS = 20;
    // The exact Q.24 product of activation and weight.
    localparam int PROD_BITS   = ACT_BITS + WEIGHT_BITS;

    // Width of the reported sum.
    localparam int OUT_BITS    = 48;
    // Width of the sign-extended accumulator view used to form the result.
    localparam int WIDE_BITS   = 64;

    // Depth of the queue between front and back.
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = 2;
    localparam int FIFO_CNT_BITS  = 3;

    // One input word.
    typedef struct packed {
        logic signed [ACT_BITS-1:0]  activation;
        logic        [CODE_BITS-1:0] weight_code;
        logic signed [COEF_BITS-1:0] block_scale;
        logic signed [COEF_BITS-1:0] block_zero_point;
        logic                        last_in_row;
    } t_in_word;

    // One product word handed from front to back.
    typedef struct packed {
        logic signed [PROD_BITS-1:0] product;
        logic                        last_in_row;
    } t_mid_word;

    // One result word.
    typedef struct packed {
        logic signed [OUT_BITS-1:0] dot_sum;
        logic                       saturated;
    } t_res_word;

endpackage

`default_nettype wire

FILE: rtl/core/aqdot_front.sv
`default_nettype none

module aqdot_front
    import aqdot_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_word  i_item,
    output logic           o_mid_valid,
    input  wire logic      i_mid_ready,
    output t_mid_word      o_mid
);

    // Stage one holds the activation next to its dequantised weight.
    logic                          r_s1_valid;
    logic signed [ACT_BITS-1:0]    r_s1_act;
    logic signed [WEIGHT_BITS-1:0] r_s1_weight;
    logic                          r_s1_last;

    // Stage two holds the exact product.
    logic      r_s2_valid;
    t_mid_word r_s2;

    logic                          s1_ready;
    logic                          s2_ready;
    logic                          in_take;
    logic [CODE_BITS-1:0]          code;
    logic signed [WEIGHT_BITS-1:0] n_weight;
    logic signed [PROD_BITS-1:0]   n_product;

    // Each stage moves on when it is empty or its successor takes its word.
    assign s2_ready = !r_s2_valid || i_mid_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign full     = !s1_ready;
    assign in_take  = push && s1_ready;

    // Weight is zero point plus code times scale, kept exact in Q.12.
    always_comb begin
        code     = i_item.weight_code & CODE_MASK;
        n_weight = WEIGHT_BITS'(signed'({1'b0, code})) * WEIGHT_BITS'(i_item.block_scale)
                 + WEIGHT_BITS'(i_item.block_zero_point);
    end

    // Product of activation and weight, exact in Q.24.
    assign n_product = PROD_BITS'(r_s1_act) * PROD_BITS'(r_s1_weight);

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= push;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_act    <= i_item.activation;
            r_s1_weight <= n_weight;
            r_s1_last   <= i_item.last_in_row;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2.product     <= n_product;
            r_s2.last_in_row <= r_s1_last;
        end
    end

    assign o_mid_valid = r_s2_valid;
    assign o_mid       = r_s2;

endmodule

`default_nettype wire

FILE: rtl/core/aqdot_fifo.sv
`default_nettype none

`include "asym_4bit_dequant_dot_product_assert.svh"

module aqdot_fifo
    import aqdot_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr_valid,
    output logic           o_wr_ready,
    input  wire t_mid_word i_wr_data,
    output logic           o_rd_valid,
    input  wire logic      i_rd_ready,
    output t_mid_word      o_rd_data
);

    t_mid_word                r_slot [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;

    logic wr_en;
    logic rd_en;

    assign o_wr_ready = (r_count != FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_slot[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

    `AQDOT_CHECK(a_fifo_count_bound, r_count <= FIFO_CNT_BITS'(FIFO_DEPTH), "queue count beyond depth")
    `AQDOT_CHECK_NEXT(a_fifo_fill, wr_en && !rd_en, r_count == $past(r_count) + 1'b1, "queue fill lost")
    `AQDOT_CHECK(a_fifo_ptrs, (r_count == '0) || (r_count == FIFO_CNT_BITS'(FIFO_DEPTH)) || (r_wr_ptr != r_rd_ptr), "queue pointers disagree with count")

endmodule

`default_nettype wire

FILE: rtl/core/aqdot_back.sv
`default_nettype none

`include "asym_4bit_dequant_dot_product_assert.svh"

module aqdot_back
    import aqdot_pkg::*;
#(
    parameter int ACC_BITS = 48
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_mid_valid,
    output logic           o_mid_ready,
    input  wire t_mid_word i_mid,
    output logic           empty,
    input  wire logic      pop,
    output t_res_word      o_result
);

    // The sum is formed one bit wider than both operands, so it never wraps.
    localparam int SUM_BITS = ((ACC_BITS > PROD_BITS) ? ACC_BITS : PROD_BITS) + 1;
    localparam logic signed [SUM_BITS-1:0] ACC_MAX =
        {{(SUM_BITS - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] ACC_MIN = ~ACC_MAX;

    logic signed [ACC_BITS-1:0] r_acc;
    logic                       r_clip;
    logic                       r_out_valid;
    t_res_word                  r_result;

    logic                        take;
    logic                        sat_hi;
    logic                        sat_lo;
    logic signed [SUM_BITS-1:0]  sum;
    logic signed [SUM_BITS-1:0]  sat_sum;
    logic signed [WIDE_BITS-1:0] sat_wide;

    // A row end waits for a free result slot; other words always go in.
    assign o_mid_ready = !i_mid.last_in_row || !r_out_valid || pop;
    assign take        = i_mid_valid && o_mid_ready;
    assign empty       = !r_out_valid;
    assign o_result    = r_result;

    // Saturating add into the accumulator.
    always_comb begin
        sum    = SUM_BITS'(r_acc) + SUM_BITS'(i_mid.product);
        sat_hi = (sum > ACC_MAX);
        sat_lo = (sum < ACC_MIN);
        if (sat_hi) begin
            sat_sum = ACC_MAX;
        end else if (sat_lo) begin
            sat_sum = ACC_MIN;
        end else begin
            sat_sum = sum;
        end
        sat_wide = WIDE_BITS'(sat_sum);
    end

    // Accumulator, clip flag and result slot state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                if (i_mid.last_in_row) begin
                    r_acc  <= '0;
                    r_clip <= 1'b0;
                end else begin
                    r_acc  <= ACC_BITS'(sat_sum);
                    r_clip <= r_clip || sat_hi || sat_lo;
                end
            end
            if (take && i_mid.last_in_row) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result word of a finished row.
    always_ff @(posedge i_clk) begin
        if (take && i_mid.last_in_row) begin
            r_result.dot_sum   <= sat_wide[OUT_BITS-1:0];
            r_result.saturated <= r_clip || sat_hi || sat_lo;
        end
    end

    `AQDOT_CHECK(a_back_sat_excl, !(i_mid_valid && sat_hi && sat_lo), "sum clipped at both limits")
    `AQDOT_CHECK_NEXT(a_back_row_clear, take && i_mid.last_in_row, (r_acc == '0) && !r_clip && r_out_valid, "row end did not clear state")
    `AQDOT_CHECK(a_back_no_overwrite, !(r_out_valid && !pop && take && i_mid.last_in_row), "result slot overwritten")

endmodule

`default_nettype wire

FILE: rtl/core/asym_4bit_dequant_dot_product.sv
`default_nettype none

// Asymmetric 4-bit dequantising dot product. Each input word carries an
// activation, a 4-bit weight code and the scale and zero point of that code's
// block; the weight is rebuilt exactly as zero point plus code times scale,
// multiplied by the activation and added to a saturating accumulator of
// ACC_BITS bits. A word marked last_in_row closes the row: one result word
// with the Q.24 sum and a clip flag appears, and the accumulator restarts at
// zero. Words are taken at one per cycle while the pipeline flows, since the
// only loop is the saturating add in the back end. A row's last word is
// registered as the weight as it is taken, then as the product, then passes
// through the four-word queue before its result word is registered. A row
// end waits in the back end while the previous result has not been popped;
// the queue and the two front stages then fill behind it, and full holds
// the input until a pop frees the result slot.
module asym_4bit_dequant_dot_product
    import aqdot_pkg::*;
#(
    parameter int ACC_BITS = 48
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_word i_item,
    output logic          empty,
    input  wire logic     pop,
    output t_res_word     o_result
);

    logic      front_valid;
    logic      front_ready;
    t_mid_word front_word;
    logic      back_valid;
    logic      back_ready;
    t_mid_word back_word;

    // Dequantise and multiply.
    aqdot_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_mid_valid (front_valid),
        .i_mid_ready (front_ready),
        .o_mid       (front_word)
    );

    // Decoupling queue between front and back.
    aqdot_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_data  (front_word),
        .o_rd_valid (back_valid),
        .i_rd_ready (back_ready),
        .o_rd_data  (back_word)
    );

    // Saturating accumulate and result slot.
    aqdot_back #(
        .ACC_BITS (ACC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (back_valid),
        .o_mid_ready (back_ready),
        .i_mid       (back_word),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

FILE: sim/dot_product_checker.sv
`timescale 1ns / 100ps

// Watches both queue interfaces of the dot-product block, keeps its own
// running row sum for every word taken in and compares every result word
// popped against the oldest predicted row sum.
module dot_product_checker
    import aqdot_pkg::*;
#(
    parameter int ACC_BITS = 48
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire logic      i_full,
    input  wire t_in_word  i_item,
    input  wire logic      i_empty,
    input  wire logic      i_pop,
    input  wire t_res_word i_result,
    output int             o_fail_count,
    output int             o_pending
);

    localparam longint SUM_MAX = (longint'(1) <<< (ACC_BITS - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    longint    row_sum     = 0;
    logic      row_clipped = 1'b0;
    int        mismatches  = 0;
    t_res_word expected_rows[$];

    // Exact Q.24 product of the activation and the rebuilt Q.12 weight.
    function automatic longint element_product(input t_in_word w);
        longint weight;
        weight = longint'($signed(w.block_zero_point))
               + longint'(w.weight_code) * longint'($signed(w.block_scale));
        return longint'($signed(w.activation)) * weight;
    endfunction

    // Both channels are sampled at the clock edge on which a word moves.
    always @(posedge i_clk) begin : watch_channels
        longint    prod;
        t_res_word want;
        if (!i_rst_n) begin
            row_sum     = 0;
            row_clipped = 1'b0;
            expected_rows.delete();
        end else begin
            // Accumulate the accepted word, clipping at the accumulator limits.
            if (i_push && !i_full) begin
                prod = element_product(i_item);
                if (prod > 0 && row_sum > SUM_MAX - prod) begin
                    row_sum     = SUM_MAX;
                    row_clipped = 1'b1;
                end else if (prod < 0 && row_sum < SUM_MIN - prod) begin
                    row_sum     = SUM_MIN;
                    row_clipped = 1'b1;
                end else begin
                    row_sum = row_sum + prod;
                end
                if (i_item.last_in_row) begin
                    want.dot_sum   = row_sum[OUT_BITS-1:0];
                    want.saturated = row_clipped;
                    expected_rows.push_back(want);
                    row_sum     = 0;
                    row_clipped = 1'b0;
                end
            end

            // Compare the popped result word with the oldest prediction.
            if (i_pop && !i_empty) begin
                if (expected_rows.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result word with no row pending: sum %0d sat %0b",
                                 $realtime, i_result.dot_sum, i_result.saturated);
                    mismatches++;
                end else begin
                    want = expected_rows.pop_front();
                    if (i_result.dot_sum !== want.dot_sum
                            || i_result.saturated !== want.saturated) begin
                        if (mismatches < 10)
                            $display("%0t: row result mismatch: sum %0d sat %0b, expected %0d sat %0b",
                                     $realtime, i_result.dot_sum, i_result.saturated,
                                     want.dot_sum, want.saturated);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_rows.size();
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

// Drives rows of dot-product elements into the block, pops the row sums at a
// random pace and leaves all checking to the checker beside the block.
module testbench;
    import aqdot_pkg::*;

    localparam int ACC_BITS      = 48;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_WORDS  = 1600;
    localparam int BURST_ROWS    = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_word  i_item  = '0;
    logic      full;
    logic      empty;
    t_res_word o_result;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit hold_req    = 1'b0;

    asym_4bit_dequant_dot_product #(
        .ACC_BITS (ACC_BITS)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    dot_product_checker #(
        .ACC_BITS (ACC_BITS)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Free-running 50 MHz clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_in_word make_word(input logic [15:0] act, input logic [3:0] code,
                                           input logic [15:0] scale, input logic [15:0] zp,
                                           input logic last);
        t_in_word w;
        w.activation       = act;
        w.weight_code      = code;
        w.block_scale      = scale;
        w.block_zero_point = zp;
        w.last_in_row      = last;
        return w;
    endfunction

    // Random element, with the extremes of each signed field drawn now and then.
    function automatic t_in_word random_word(input logic last);
        t_in_word w;
        w = make_word(16'($urandom), 4'($urandom_range(0, 15)), 16'($urandom),
                      16'($urandom), last);
        if ($urandom_range(0, 7) == 0)
            w.activation = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if ($urandom_range(0, 7) == 0)
            w.block_scale = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if ($urandom_range(0, 7) == 0)
            w.block_zero_point = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        return w;
    endfunction

    // Offers one word after an optional gap and holds it until it is taken.
    task automatic send_word(input t_in_word w, input int gap);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (full);
    endtask

    // Sender: directed rows, then random rows.
    initial begin : sender
        int   sent;
        int   row_len;
        bit   row_busy;
        bit   burst_done;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // An all-zero row and a single-element row at the top extremes.
        send_word(make_word(16'h0000, 4'h0, 16'h0000, 16'h0000, 1'b1), 0);
        send_word(make_word(16'h7FFF, 4'hF, 16'h7FFF, 16'h7FFF, 1'b1), 1);

        // A short row mixing the most negative and most positive values.
        send_word(make_word(16'h8000, 4'hF, 16'h8000, 16'h8000, 1'b0), 0);
        send_word(make_word(16'h7FFF, 4'h0, 16'h8000, 16'h7FFF, 1'b0), 2);
        send_word(make_word(16'h8000, 4'hF, 16'h7FFF, 16'h8000, 1'b0), 0);
        send_word(make_word(16'h1234, 4'h7, 16'hFFFF, 16'h0001, 1'b1), 3);

        // Every weight code in one row.
        for (int code = 0; code < 16; code++)
            send_word(make_word(16'h1000, 4'(code), 16'h0800, 16'hC000, (code == 15)),
                      code % 3);

        // Short rows with negative and positive steps, then a single-word row.
        for (int k = 0; k < 3; k++)
            send_word(make_word(16'h1000, 4'h1, 16'hF000, 16'h0000, (k == 2)), 0);
        for (int k = 0; k < 2; k++)
            send_word(make_word(16'h1000, 4'h1, 16'h1000, 16'h0000, (k == 1)), 0);
        send_word(make_word(16'h0100, 4'h3, 16'h0010, 16'hFF00, 1'b1), 0);

        // Let every row sum drain before the random part.
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        sent       = 0;
        burst_done = 1'b0;
        while (sent < RANDOM_WORDS) begin
            // Halfway through, single-word rows back to back while the
            // receiver holds off, so that the result slot and the queue behind it fill.
            if (!burst_done && sent >= RANDOM_WORDS / 2) begin
                burst_done = 1'b1;
                hold_req   = 1'b1;
                for (int k = 0; k < BURST_ROWS; k++)
                    send_word(random_word(1'b1), 0);
                sent += BURST_ROWS;
            end
            row_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                   : $urandom_range(1, 8);
            row_busy = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < row_len; k++)
                send_word(random_word(k == row_len - 1),
                          row_busy ? 0 : $urandom_range(0, 16));
            sent += row_len;
        end
        push <= 1'b0;
        @(posedge i_clk);

        // Wait for every row sum, then let anything stray arrive before the verdict.
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: random pauses before each pop, with quiet stretches and one
    // long hold-off when the sender asks for it.
    initial begin : receiver
        int wait_cycles;
        int pops;
        bit quiet;
        pops  = 0;
        quiet = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                pop     <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (pops % 8 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            wait_cycles = quiet ? 0 : $urandom_range(0, 16);
            if (wait_cycles > 0) begin
                pop <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            pops++;
        end
    end

endmodule
